/* hw/rtl/mre_pkg.sv */
package mre_pkg;

    // value format: signed fixed point, 48 bits
    localparam int QW = 48;
    // exact product of two magnitudes
    localparam int PW = 2 * QW;
    // half word for the partial products
    localparam int HW = QW / 2;

    // parameter store layout
    localparam int K_BASE      = 0;
    localparam int R_BASE      = 9;
    localparam int T_BASE      = 18;
    localparam int MIRROR_BASE = 21;
    localparam int MIRROR_WORDS = 4;

    localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

    // request to the shared multiplier
    typedef struct packed {
        logic          start;
        logic [QW-1:0] a;
        logic [QW-1:0] b;
    } t_mul_req;

endpackage

/* hw/rtl/mre_mul.sv */
module mre_mul (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mre_pkg::t_mul_req    i_req,
    output logic                 o_done,
    output logic [mre_pkg::PW-1:0] o_prod
);

    logic [mre_pkg::QW-1:0] r_a;
    logic [mre_pkg::QW-1:0] r_b;
    logic [mre_pkg::QW-1:0] r_pp;
    logic [1:0]             r_psel;
    logic [2:0]             r_step;
    logic                   r_busy;
    logic                   r_done;
    logic [mre_pkg::PW-1:0] r_prod;

    logic [mre_pkg::HW-1:0] opa;
    logic [mre_pkg::HW-1:0] opb;
    logic [mre_pkg::PW-1:0] pp_shifted;

    // step order: lo*lo, lo*hi, hi*lo, hi*hi
    assign opa = r_step[1] ? r_a[mre_pkg::QW-1:mre_pkg::HW] : r_a[mre_pkg::HW-1:0];
    assign opb = r_step[0] ? r_b[mre_pkg::QW-1:mre_pkg::HW] : r_b[mre_pkg::HW-1:0];

    always_comb begin
        case (r_psel)
            2'd0:    pp_shifted = mre_pkg::PW'(r_pp);
            2'd3:    pp_shifted = mre_pkg::PW'(r_pp) << mre_pkg::QW;
            default: pp_shifted = mre_pkg::PW'(r_pp) << mre_pkg::HW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_prod <= '0;
                r_step <= 3'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_step != 3'd0) begin
                    r_prod <= r_prod + pp_shifted;
                end
                if (r_step < 3'd4) begin
                    r_pp   <= opa * opb;
                    r_psel <= r_step[1:0];
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

/* hw/rtl/mre_div.sv */
module mre_div #(
    parameter int DW = 74,
    parameter int VW = 49
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quo,
    output logic [VW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [VW:0]   rem_sh;
    logic [VW:0]   rem_diff;
    logic          ge;

    // one quotient bit per cycle, restoring
    assign rem_sh   = {r_rem, r_dvd[DW-1]};
    assign ge       = rem_sh >= {1'b0, r_dvs};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
                r_cnt  <= CW'(DW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_diff[VW-1:0] : rem_sh[VW-1:0];
                r_dvd <= {r_dvd[DW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_dvd;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/mre_sqrt.sv */
module mre_sqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [mre_pkg::PW-1:0]   i_rad,
    output logic                     o_done,
    output logic [mre_pkg::QW-1:0]   o_root,
    output logic [mre_pkg::QW+1:0]   o_rem
);

    localparam int QW = mre_pkg::QW;
    localparam int CW = $clog2(QW + 1);

    logic [mre_pkg::PW-1:0] r_rad;
    logic [QW+1:0]          r_rem;
    logic [QW-1:0]          r_root;
    logic [CW-1:0]          r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [QW+3:0]          rem_sh;
    logic [QW+3:0]          trial;
    logic [QW+3:0]          rem_diff;
    logic                   ge;

    // two radicand bits per cycle, one root bit
    assign rem_sh   = {r_rem, r_rad[mre_pkg::PW-1:mre_pkg::PW-2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CW'(QW);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? rem_diff[QW+1:0] : rem_sh[QW+1:0];
                r_root <= {r_root[QW-2:0], ge};
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/mirror_reprojection_error.sv */
// Mirror reprojection error evaluator. A word with i_operation = 0 loads one
// signed Q24.24 parameter into slot i_slot (0-8 intrinsics, 9-17 rotation,
// 18-20 translation, then normal x/y/z and distance for each mirror); loads
// give no result and leave the block idle. A word with i_operation = 1
// evaluates one point: rotate and translate the model point, reflect it in the
// selected mirror, project through the intrinsics, divide by depth and report
// the rounded pixel distance to the observed point. Zero depth sets
// o_depth_fault and the point is not summed. The point marked i_last also
// reports the rounded mean of the summed errors, if there are any, and clears
// the sums. Every point gives exactly one result word. A point takes 24
// multiply steps through one 4-pass 24x24 multiplier, 4 plain adds, two
// bit-serial depth divisions and the bit-serial square root, and a last
// point that reports a mean also uses the divider once more. A finished
// result that cannot leave the output register keeps the block busy while
// it waits. o_stall is asserted while a point is in progress; one finished
// result can wait in the output register while the next word is taken.
module mirror_reprojection_error #(
    parameter int MIRRORS   = 4,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_operation,
    input  logic [5:0]                  i_slot,
    input  logic signed [47:0]          i_word,
    input  logic [1:0]                  i_mirror,
    input  logic signed [47:0]          i_model_x,
    input  logic signed [47:0]          i_model_y,
    input  logic signed [47:0]          i_model_z,
    input  logic signed [47:0]          i_image_u,
    input  logic signed [47:0]          i_image_v,
    input  logic                        i_last,
    // result word channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [46:0]                 o_point_error,
    output logic [46:0]                 o_mean_error,
    output logic                        o_mean_valid,
    output logic                        o_depth_fault
);

    localparam int QW          = mre_pkg::QW;
    localparam int PW          = mre_pkg::PW;
    localparam int STORE_DEPTH = mre_pkg::MIRROR_BASE + mre_pkg::MIRROR_WORDS * MIRRORS;
    localparam int AW          = $clog2(STORE_DEPTH);
    // dividend must hold |num| << (FRAC_BITS+1) plus |den|, and the 64-bit error sum
    localparam int DW          = (50 + FRAC_BITS > 64) ? 50 + FRAC_BITS : 64;
    localparam int VW          = QW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_FETCH, S_OPER, S_MWAIT, S_RND, S_ACC, S_KSET, S_CHECK,
        S_DIV_GO, S_DIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_ROOT_GO, S_ROOT_WAIT,
        S_SUM, S_LAST, S_MEAN_GO, S_MEAN_WAIT, S_DONE
    } t_state;

    // which dot product the sequencer is on
    typedef enum logic [1:0] {
        PH_P,   // p = R*x + T
        PH_S,   // s = n.p + d
        PH_C,   // c = p + k*n
        PH_Q    // q = K*c
    } t_phase;

    function automatic logic [QW-1:0] f_mag(input logic signed [QW-1:0] v);
        return v[QW-1] ? QW'(-v) : QW'(v);
    endfunction

    // saturate a two-bit-grown sum to the value range
    function automatic logic signed [QW-1:0] f_sat(input logic signed [QW+1:0] v);
        logic signed [QW-1:0] res;
        if (v[QW+1:QW-1] == 3'b000 || v[QW+1:QW-1] == 3'b111) begin
            res = v[QW-1:0];
        end else begin
            res = v[QW+1] ? mre_pkg::Q_MIN : mre_pkg::Q_MAX;
        end
        return res;
    endfunction

    function automatic logic signed [QW+1:0] f_sx(input logic signed [QW-1:0] v);
        return {{2{v[QW-1]}}, v};
    endfunction

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    t_state               r_state;
    t_phase               r_phase;
    logic [1:0]           r_i;
    logic [1:0]           r_j;
    logic [7:0]           r_base;

    logic signed [QW-1:0] r_store [STORE_DEPTH];
    logic signed [QW-1:0] r_rdata;

    logic signed [QW-1:0] r_x [3];
    logic signed [QW-1:0] r_p [3];
    logic signed [QW-1:0] r_c [3];
    logic signed [QW-1:0] r_q [3];
    logic signed [QW-1:0] r_k;
    logic signed [QW-1:0] r_acc;
    logic signed [QW-1:0] r_term;
    logic                 r_neg;
    logic signed [QW-1:0] r_u;
    logic signed [QW-1:0] r_v;
    logic                 r_last;
    logic signed [QW-1:0] r_du;
    logic signed [QW-1:0] r_dv;
    logic [PW-1:0]        r_ssum;

    logic [46:0]          r_err;
    logic [46:0]          r_mean;
    logic                 r_mv;
    logic                 r_flt;

    logic [63:0]          r_sum;
    logic [31:0]          r_cnt;

    logic                 r_ovalid;
    logic [46:0]          r_o_err;
    logic [46:0]          r_o_mean;
    logic                 r_o_mv;
    logic                 r_o_flt;

    // ---------------------------------------------------------------
    // shared multiplier and divider, and the square root unit
    // ---------------------------------------------------------------
    mre_pkg::t_mul_req    mreq;
    logic                 mul_done;
    logic [PW-1:0]        mul_prod;

    logic                 div_start;
    logic [DW-1:0]        div_dvd;
    logic [VW-1:0]        div_dvs;
    logic                 div_done;
    logic [DW-1:0]        div_quo;
    logic [VW-1:0]        div_rem;

    logic                 sq_done;
    logic [QW-1:0]        sq_root;
    logic [QW+1:0]        sq_rem;

    mre_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    mre_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    mre_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ROOT_GO),
        .i_rad   (r_ssum),
        .o_done  (sq_done),
        .o_root  (sq_root),
        .o_rem   (sq_rem)
    );

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    logic       accept;
    logic [1:0] mir;
    logic       slot_ok;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign slot_ok = (8'(i_slot) < 8'(STORE_DEPTH));

    // mirror index wraps at the mirror count
    always_comb begin
        mir = i_mirror;
        for (int n = 0; n < 3; n++) begin
            if (int'(mir) >= MIRRORS) begin
                mir = mir - 2'(MIRRORS);
            end
        end
    end

    // ---------------------------------------------------------------
    // operand and address selection
    // ---------------------------------------------------------------
    logic [7:0]           addr;
    logic signed [QW-1:0] bop;
    logic                 add_only;
    logic                 row_end;

    always_comb begin
        case (r_phase)
            PH_P: addr = (r_j == 2'd3) ? 8'(mre_pkg::T_BASE) + 8'(r_i)
                                       : 8'(mre_pkg::R_BASE) + 8'(r_i) * 8'd3 + 8'(r_j);
            PH_S: addr = r_base + 8'(r_j);
            PH_C: addr = r_base + 8'(r_i);
            PH_Q: addr = 8'(mre_pkg::K_BASE) + 8'(r_i) * 8'd3 + 8'(r_j);
            default: addr = '0;
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_C: bop = r_k;
            default: begin
                case (r_j)
                    2'd0: bop = (r_phase == PH_P) ? r_x[0] : (r_phase == PH_S) ? r_p[0] : r_c[0];
                    2'd1: bop = (r_phase == PH_P) ? r_x[1] : (r_phase == PH_S) ? r_p[1] : r_c[1];
                    default: bop = (r_phase == PH_P) ? r_x[2]
                                 : (r_phase == PH_S) ? r_p[2] : r_c[2];
                endcase
            end
        endcase
    end

    // translation and mirror distance are plain adds
    assign add_only = (r_phase == PH_P || r_phase == PH_S) && (r_j == 2'd3);

    always_comb begin
        case (r_phase)
            PH_P, PH_S: row_end = (r_j == 2'd3);
            PH_C:       row_end = 1'b1;
            default:    row_end = (r_j == 2'd2);
        endcase
    end

    logic [QW-1:0] sq_mag;
    assign sq_mag = f_mag((r_i == 2'd0) ? r_du : r_dv);

    always_comb begin
        mreq.start = (r_state == S_OPER && !add_only) || (r_state == S_SQ_GO);
        mreq.a     = (r_state == S_SQ_GO) ? sq_mag : f_mag(r_rdata);
        mreq.b     = (r_state == S_SQ_GO) ? sq_mag : f_mag(bop);
    end

    // depth division and mean division share one divider
    logic signed [QW-1:0] qnum;
    assign qnum      = (r_i == 2'd0) ? r_q[0] : r_q[1];
    assign div_start = (r_state == S_DIV_GO) || (r_state == S_MEAN_GO);
    always_comb begin
        if (r_state == S_MEAN_GO) begin
            div_dvd = DW'(r_sum);
            div_dvs = VW'(r_cnt);
        end else begin
            div_dvd = (DW'(f_mag(qnum)) << (FRAC_BITS + 1)) + DW'(f_mag(r_q[2]));
            div_dvs = {f_mag(r_q[2]), 1'b0};
        end
    end

    // ---------------------------------------------------------------
    // datapath arithmetic
    // ---------------------------------------------------------------
    // product rounding, ties away from zero
    logic [PW:0]          rnd;
    logic [PW:0]          rnd_sh;
    logic                 rnd_big;
    logic signed [QW-1:0] term_mul;

    assign rnd     = {1'b0, mul_prod} + ((PW + 1)'(1) << (FRAC_BITS - 1));
    assign rnd_sh  = rnd >> FRAC_BITS;
    assign rnd_big = |rnd_sh[PW:QW-1];
    always_comb begin
        if (r_neg) begin
            term_mul = rnd_big ? mre_pkg::Q_MIN : -$signed(rnd_sh[QW-1:0]);
        end else begin
            term_mul = rnd_big ? mre_pkg::Q_MAX : $signed(rnd_sh[QW-1:0]);
        end
    end

    logic signed [QW-1:0] n_acc;
    assign n_acc = f_sat(f_sx(r_acc) + f_sx(r_term));

    // k = -2 * s, saturated
    logic signed [QW+1:0] k_wide;
    assign k_wide = -$signed({r_acc[QW-1], r_acc, 1'b0});

    // quotient to signed value, then difference to the observation
    logic                 q_neg;
    logic                 q_big;
    logic signed [QW-1:0] qv;
    logic signed [QW-1:0] img;
    logic signed [QW-1:0] n_diff;

    assign q_neg = qnum[QW-1] ^ r_q[2][QW-1];
    assign q_big = |div_quo[DW-1:QW-1];
    always_comb begin
        if (q_neg) begin
            qv = q_big ? mre_pkg::Q_MIN : -$signed(div_quo[QW-1:0]);
        end else begin
            qv = q_big ? mre_pkg::Q_MAX : $signed(div_quo[QW-1:0]);
        end
    end
    assign img    = (r_i == 2'd0) ? r_u : r_v;
    assign n_diff = f_sat(f_sx(qv) - f_sx(img));

    // root rounding: bump when remainder exceeds the root
    logic          root_inc;
    logic [QW:0]   root_rnd;
    logic [46:0]   n_err;
    assign root_inc = sq_rem > (QW + 2)'(sq_root);
    assign root_rnd = (QW + 1)'(sq_root) + (QW + 1)'(root_inc);
    assign n_err    = (|root_rnd[QW:QW-1]) ? {47{1'b1}} : root_rnd[46:0];

    // error sum and count, both saturating
    logic [64:0] sum_wide;
    assign sum_wide = {1'b0, r_sum} + 65'(r_err);

    // mean rounding: ties up
    logic          mean_inc;
    logic [DW:0]   mean_wide;
    logic [46:0]   n_mean;
    assign mean_inc  = {div_rem, 1'b0} >= (VW + 1)'(r_cnt);
    assign mean_wide = (DW + 1)'(div_quo) + (DW + 1)'(mean_inc);
    assign n_mean    = (|mean_wide[DW:QW-1]) ? {47{1'b1}} : mean_wide[46:0];

    // ---------------------------------------------------------------
    // parameter store
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept && !i_operation && slot_ok) begin
            r_store[AW'(i_slot)] <= i_word;
        end
        r_rdata <= r_store[AW'(addr)];
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_P;
            r_i      <= 2'd0;
            r_j      <= 2'd0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_operation) begin
                        r_x[0]  <= i_model_x;
                        r_x[1]  <= i_model_y;
                        r_x[2]  <= i_model_z;
                        r_u     <= i_image_u;
                        r_v     <= i_image_v;
                        r_last  <= i_last;
                        r_base  <= 8'(mre_pkg::MIRROR_BASE) + {4'b0000, mir, 2'b00};
                        r_phase <= PH_P;
                        r_i     <= 2'd0;
                        r_j     <= 2'd0;
                        r_acc   <= '0;
                        r_err   <= '0;
                        r_mean  <= '0;
                        r_mv    <= 1'b0;
                        r_flt   <= 1'b0;
                        r_state <= S_FETCH;
                    end
                end
                // store read address settles, data registered
                S_FETCH: r_state <= S_OPER;
                S_OPER: begin
                    if (add_only) begin
                        r_term  <= r_rdata;
                        r_state <= S_ACC;
                    end else begin
                        r_neg   <= r_rdata[QW-1] ^ bop[QW-1];
                        r_state <= S_MWAIT;
                    end
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    r_term  <= term_mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= n_acc;
                    if (!row_end) begin
                        r_j     <= r_j + 2'd1;
                        r_state <= S_FETCH;
                    end else begin
                        r_j     <= 2'd0;
                        r_state <= S_FETCH;
                        case (r_phase)
                            PH_P: begin
                                r_p[r_i] <= n_acc;
                                r_acc    <= '0;
                                if (r_i == 2'd2) begin
                                    r_phase <= PH_S;
                                    r_i     <= 2'd0;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end
                            PH_S: r_state <= S_KSET;
                            PH_C: begin
                                r_c[r_i] <= n_acc;
                                if (r_i == 2'd2) begin
                                    r_phase <= PH_Q;
                                    r_i     <= 2'd0;
                                    r_acc   <= '0;
                                end else begin
                                    r_i   <= r_i + 2'd1;
                                    r_acc <= r_p[r_i + 2'd1];
                                end
                            end
                            default: begin
                                r_q[r_i] <= n_acc;
                                r_acc    <= '0;
                                if (r_i == 2'd2) begin
                                    r_state <= S_CHECK;
                                end else begin
                                    r_i <= r_i + 2'd1;
                                end
                            end
                        endcase
                    end
                end
                S_KSET: begin
                    r_k     <= f_sat(k_wide);
                    r_acc   <= r_p[0];
                    r_phase <= PH_C;
                    r_i     <= 2'd0;
                    r_j     <= 2'd0;
                    r_state <= S_FETCH;
                end
                S_CHECK: begin
                    r_i <= 2'd0;
                    if (r_q[2] == '0) begin
                        r_flt   <= 1'b1;
                        r_state <= S_LAST;
                    end else begin
                        r_state <= S_DIV_GO;
                    end
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        if (r_i == 2'd0) begin
                            r_du    <= n_diff;
                            r_i     <= 2'd1;
                            r_state <= S_DIV_GO;
                        end else begin
                            r_dv    <= n_diff;
                            r_i     <= 2'd0;
                            r_state <= S_SQ_GO;
                        end
                    end
                end
                S_SQ_GO: r_state <= S_SQ_WAIT;
                S_SQ_WAIT: begin
                    if (mul_done) begin
                        if (r_i == 2'd0) begin
                            r_ssum  <= mul_prod;
                            r_i     <= 2'd1;
                            r_state <= S_SQ_GO;
                        end else begin
                            r_ssum  <= r_ssum + mul_prod;
                            r_state <= S_ROOT_GO;
                        end
                    end
                end
                S_ROOT_GO: r_state <= S_ROOT_WAIT;
                S_ROOT_WAIT: begin
                    if (sq_done) begin
                        r_err   <= n_err;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum <= sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
                    if (r_cnt != {32{1'b1}}) begin
                        r_cnt <= r_cnt + 32'd1;
                    end
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    if (r_last && r_cnt != '0) begin
                        r_state <= S_MEAN_GO;
                    end else begin
                        if (r_last) begin
                            r_sum <= '0;
                            r_cnt <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_MEAN_GO: r_state <= S_MEAN_WAIT;
                S_MEAN_WAIT: begin
                    if (div_done) begin
                        r_mean  <= n_mean;
                        r_mv    <= 1'b1;
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || !i_stall) begin
                        r_o_err  <= r_err;
                        r_o_mean <= r_mean;
                        r_o_mv   <= r_mv;
                        r_o_flt  <= r_flt;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_point_error = r_o_err;
    assign o_mean_error  = r_o_mean;
    assign o_mean_valid  = r_o_mv;
    assign o_depth_fault = r_o_flt;

endmodule
